@@ rtl/rte_pkg.sv @@
package rte_pkg;

   localparam int XLEN = 64;
   localparam int CODE_W = 4;
   localparam int EXC_DELEG_W = 16;
   localparam int INT_DELEG_W = 12;
   localparam int CSR_INDEX_W = 2;

   // Privilege mode encodings.
   localparam logic [1:0] MODE_USER       = 2'd0;
   localparam logic [1:0] MODE_SUPERVISOR = 2'd1;
   localparam logic [1:0] MODE_MACHINE    = 2'd3;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EXC_DELEG = 2'd0,
      CSR_INT_DELEG = 2'd1,
      CSR_MTVEC     = 2'd2,
      CSR_STVEC     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [XLEN-1:0]   current_pc;
      logic [1:0]        current_mode;
      logic              interrupt_flag;
      logic [CODE_W-1:0] trap_code;
      logic              machine_ie_in;
      logic              supervisor_ie_in;
   } req_payload_type;

   typedef struct packed {
      logic [XLEN-1:0] next_pc;
      logic [1:0]      next_mode;
      logic            to_supervisor;
      logic [XLEN-1:0] saved_pc;
      logic [XLEN-1:0] cause_word;
      logic            new_ie;
      logic            new_pie;
      logic [1:0]      new_pp;
   } rsp_payload_type;

   typedef struct packed {
      logic [EXC_DELEG_W-1:0] exception_delegation;
      logic [INT_DELEG_W-1:0] interrupt_delegation;
      logic [XLEN-1:0]        machine_vector_base;
      logic [XLEN-1:0]        supervisor_vector_base;
   } cfg_type;

endpackage

@@ rtl/rte_if.sv @@
interface rte_req_if;
   logic                     valid;
   logic                     ready;
   rte_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rte_rsp_if;
   logic                     valid;
   logic                     ready;
   rte_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/riscv_trap_entry_unit.sv @@
// RISC-V trap entry unit. Each request describes one trap (pc, privilege mode,
// interrupt flag, cause code and the current MIE/SIE bits) and produces exactly
// one response: handler pc, new mode, delegation flag, saved epc, cause word
// and the new IE/PIE/PP bits of the target level. A new request can be taken
// every cycle unless both registers are full and the response is stalled; the
// request passes through the request register and the response register that
// frame the decision logic. Under backpressure both registers hold, so the unit
// buffers up to two requests. The delegation and vector registers are written
// through the csr_ port and should only be changed while no request is in
// flight; all of them reset to zero.
module riscv_trap_entry_unit (
   input  logic                            clock,
   input  logic                            reset,
   rte_req_if.sink                         req_bus,
   rte_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [rte_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rte_pkg::XLEN-1:0]        csr_wdata
);

   rte_pkg::cfg_type         cfg;
   rte_pkg::req_payload_type req_ff;
   rte_pkg::rsp_payload_type rsp_in;
   rte_pkg::rsp_payload_type rsp_ff;
   logic                     s1_valid_ff;
   logic                     s2_valid_ff;
   logic                     s1_advance;
   logic                     s2_advance;
   logic                     req_take;

   rte_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rte_decide u_decide (
      .req (req_ff),
      .cfg (cfg),
      .rsp (rsp_in)
   );

   // The response register loads when it is empty or being drained; the
   // request register loads whenever its content moves on or it is empty.
   assign s2_advance = !s2_valid_ff || rsp_bus.ready;
   assign s1_advance = !s1_valid_ff || s2_advance;
   assign req_bus.ready = s1_advance;
   assign req_take = req_bus.valid && s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_advance) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_advance) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_bus.payload;
      end
      if (s2_advance && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid = s2_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // An accepted request always occupies the request register next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted request not captured");

   // A request moving out of the first stage becomes a visible response.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_advance |=> rsp_bus.valid)
      else $error("request lost between stages");

   // A machine-mode trap is never delegated.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_advance && req_ff.current_mode == rte_pkg::MODE_MACHINE
      |=> !rsp_bus.payload.to_supervisor &&
          rsp_bus.payload.new_pp == rte_pkg::MODE_MACHINE)
      else $error("machine trap delegated");

   // Delegation flag and target mode agree, and the target enable is cleared.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         (rsp_bus.payload.to_supervisor ==
          (rsp_bus.payload.next_mode == rte_pkg::MODE_SUPERVISOR)) &&
         !rsp_bus.payload.new_ie)
      else $error("inconsistent target mode");

endmodule

@@ rtl/rte_csr.sv @@
module rte_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rte_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rte_pkg::XLEN-1:0]          csr_wdata,
   output rte_pkg::cfg_type                  cfg
);

   rte_pkg::cfg_type cfg_ff;
   rte_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (rte_pkg::csr_index_type'(csr_index))
            rte_pkg::CSR_EXC_DELEG: begin
               cfg_in.exception_delegation = csr_wdata[rte_pkg::EXC_DELEG_W-1:0];
            end
            rte_pkg::CSR_INT_DELEG: begin
               cfg_in.interrupt_delegation = csr_wdata[rte_pkg::INT_DELEG_W-1:0];
            end
            rte_pkg::CSR_MTVEC: begin
               cfg_in.machine_vector_base = csr_wdata;
            end
            rte_pkg::CSR_STVEC: begin
               cfg_in.supervisor_vector_base = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/rte_decide.sv @@
module rte_decide (
   input  rte_pkg::req_payload_type req,
   input  rte_pkg::cfg_type         cfg,
   output rte_pkg::rsp_payload_type rsp
);

   logic [rte_pkg::EXC_DELEG_W-1:0] int_deleg_ext;
   logic                            deleg_bit;
   logic                            to_s;
   logic [rte_pkg::XLEN-1:0]        tvec;
   logic [rte_pkg::XLEN-1:0]        offset;
   logic [rte_pkg::XLEN-1:0]        pc_minus;

   always_comb begin
      // Interrupt codes above the implemented delegation bits read as zero.
      int_deleg_ext = {{(rte_pkg::EXC_DELEG_W - rte_pkg::INT_DELEG_W){1'b0}},
                       cfg.interrupt_delegation};
      deleg_bit = req.interrupt_flag ? int_deleg_ext[req.trap_code]
                                     : cfg.exception_delegation[req.trap_code];
      to_s = (req.current_mode == rte_pkg::MODE_USER ||
              req.current_mode == rte_pkg::MODE_SUPERVISOR) && deleg_bit;
      tvec = to_s ? cfg.supervisor_vector_base : cfg.machine_vector_base;
      offset = (tvec[0] && req.interrupt_flag)
             ? {{(rte_pkg::XLEN - rte_pkg::CODE_W - 2){1'b0}}, req.trap_code, 2'b00}
             : '0;
      pc_minus = req.current_pc - rte_pkg::XLEN'(4);

      rsp.next_pc = {tvec[rte_pkg::XLEN-1:1], 1'b0} + offset;
      rsp.next_mode = to_s ? rte_pkg::MODE_SUPERVISOR : rte_pkg::MODE_MACHINE;
      rsp.to_supervisor = to_s;
      rsp.saved_pc = {pc_minus[rte_pkg::XLEN-1:1], 1'b0};
      rsp.cause_word = {req.interrupt_flag,
                        {(rte_pkg::XLEN - rte_pkg::CODE_W - 1){1'b0}},
                        req.trap_code};
      rsp.new_ie = 1'b0;
      rsp.new_pie = to_s ? req.supervisor_ie_in : req.machine_ie_in;
      // SPP is a single bit: zero from user, one from supervisor.
      if (to_s) begin
         rsp.new_pp = (req.current_mode == rte_pkg::MODE_USER) ? rte_pkg::MODE_USER
                                                              : rte_pkg::MODE_SUPERVISOR;
      end else begin
         rsp.new_pp = req.current_mode;
      end
   end

endmodule
